>>> rtl/ppm_pkg.sv
`timescale 1ns / 1ps
package ppm_pkg;
   localparam int MaxNodes = 1024;
   localparam int NodeBits = 10;
   localparam int CountBits = 11;
   localparam int FracBits = 16;
   localparam int ValBits = 32;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SHAPE_TRI  = 2'd0,
      SHAPE_BEZ  = 2'd1,
      SHAPE_SINE = 2'd2,
      SHAPE_NONE = 2'd3
   } shape_type;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SMALL = 2'd2;

   localparam logic CSR_NODE_COUNT = 1'b0;
   localparam logic CSR_THRESHOLD  = 1'b1;

   function automatic logic [16:0] sine_point(input logic [5:0] k);
      logic [4:0] j;
      logic [16:0] v;
      j = (k <= 6'd16) ? k[4:0] : 5'(6'd32 - k);
      case (j)
         5'd0: v = 17'd0;      5'd1: v = 17'd6424;   5'd2: v = 17'd12785;
         5'd3: v = 17'd19024;  5'd4: v = 17'd25080;  5'd5: v = 17'd30893;
         5'd6: v = 17'd36410;  5'd7: v = 17'd41576;  5'd8: v = 17'd46341;
         5'd9: v = 17'd50660;  5'd10: v = 17'd54491; 5'd11: v = 17'd57798;
         5'd12: v = 17'd60547; 5'd13: v = 17'd62714; 5'd14: v = 17'd64277;
         5'd15: v = 17'd65220; 5'd16: v = 17'd65536;
         default: v = 17'd0;
      endcase
      if (k > 6'd32) v = 17'd0;
      return v;
   endfunction

   function automatic logic [31:0] mag(input logic [31:0] v);
      return v[31] ? 32'(-v) : v;
   endfunction
endpackage

>>> rtl/pulse_profile_peak_merge_top.sv
`timescale 1ns / 1ps
// A clear sweeps the whole store, a read fetches the node and its neighbours, and a rejected
// add responds without touching the store; an add runs a restoring division per node in the span.
// Throughput: one word at a time; busy stays high until the result strobe.
// The receiver cannot stall; each result is shown for exactly one cycle on rsp_valid.
// Reset is synchronous: the store is swept to zero after reset,
// during which busy is high; registers return to node_count 1024, threshold 1.
module pulse_profile_peak_merge_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [9:0]  req_first_node,
   input  logic [9:0]  req_last_node,
   input  logic signed [31:0] req_amplitude,
   input  logic [1:0]  req_shape,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_node_index,
   output logic signed [31:0] rsp_node_value,
   output logic        rsp_is_peak,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_CHECK, S_SETUP, S_DIV, S_T, S_SM1, S_SM2, S_SM3,
      S_SIN1, S_SIN2, S_SCALE, S_RD, S_MERGE, S_NEXT,
      S_RA, S_RB, S_RC, S_RD2, S_RESP
   } state_type;

   state_type state_ff;
   logic [ppm_pkg::CountBits-1:0] count_ff;
   logic [30:0] thr_ff;
   logic [1:0]  op_ff, shape_ff;
   logic [9:0]  first_ff, last_ff, mid_ff, node_ff;
   logic [31:0] amp_ff;
   logic [1:0]  status_ff;
   logic        rsp_valid_ff, peak_ff;
   logic [31:0] val_out_ff;
   logic [9:0]  idx_ff;
   // Division state: quotient of (k<<16)/d.
   logic [9:0]  den_ff;
   logic [26:0] rem_ff;
   logic [16:0] quo_ff;
   logic [4:0]  dstep_ff;
   logic [16:0] t_ff, w_ff;
   logic [33:0] u_ff;
   logic [63:0] prod_ff;
   logic [31:0] newv_ff;
   logic        fall_ff;
   logic [10:0] n_use;

   // One synchronous store with one port and a registered read.
   logic [31:0] mem [ppm_pkg::MaxNodes];
   logic [9:0]  maddr;
   logic        mwe;
   logic [31:0] mwd, mrd_ff;
   logic [31:0] m0_ff, m1_ff;

   // A clear that came from a word (not from reset) owes a response.
   function automatic logic rsp_pending();
      return idx_ff == 10'd1;
   endfunction

   always_ff @(posedge clock) begin
      if (mwe) mem[maddr] <= mwd;
      mrd_ff <= mem[maddr];
   end

   always_comb begin
      if (count_ff < 11'd2) n_use = 11'd2;
      else if (count_ff > 11'(ppm_pkg::MaxNodes)) n_use = 11'(ppm_pkg::MaxNodes);
      else n_use = count_ff;
   end

   logic [10:0] n_last;
   assign n_last = n_use - 11'd1;

   always_comb begin
      mwe = 1'b0;
      mwd = newv_ff;
      maddr = node_ff;
      case (state_ff)
         S_CLEAR: begin mwe = 1'b1; mwd = '0; end
         S_MERGE: mwe = (ppm_pkg::mag(mrd_ff) < ppm_pkg::mag(newv_ff));
         S_RA: maddr = first_ff;
         S_RB: maddr = (first_ff == 10'd0) ? 10'd1 : 10'(first_ff - 10'd1);
         S_RC: maddr = 10'(first_ff + 10'd1);
         default: ;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_node_index = idx_ff;
   assign rsp_node_value = val_out_ff;
   assign rsp_is_peak = peak_ff;

   logic [26:0] trial;
   logic [16:0] p32;
   logic [16:0] sa, sb, sdiff;
   logic [33:0] u_in;
   assign trial = {rem_ff[25:0], 1'b0};
   assign p32 = {t_ff[11:0], 5'd0};
   assign sa = ppm_pkg::sine_point({1'b0, t_ff[15:11]} | {t_ff[16], 5'd0});
   assign sb = ppm_pkg::sine_point(6'(({1'b0, t_ff[15:11]} | {t_ff[16], 5'd0}) + 6'd1));
   assign sdiff = (sb >= sa) ? 17'(sb - sa) : 17'(sa - sb);
   assign u_in = 34'(t_ff) * 34'(t_ff) + 34'd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         state_ff <= S_CLEAR;
         node_ff <= '0;
         op_ff <= ppm_pkg::OP_NONE;
         idx_ff <= '0;
         count_ff <= 11'd1024;
         thr_ff <= 31'd1;
      end else begin
         rsp_valid_ff <= (state_ff == S_RESP);
         if (csr_valid && csr_ready) begin
            if (csr_index == ppm_pkg::CSR_NODE_COUNT) count_ff <= csr_data[10:0];
            else thr_ff <= csr_data[30:0];
         end
         case (state_ff)
            S_CLEAR: begin
               node_ff <= 10'(node_ff + 10'd1);
               if (node_ff == 10'(ppm_pkg::MaxNodes - 1)) begin
                  if (op_ff == ppm_pkg::OP_CLEAR && rsp_pending()) state_ff <= S_RESP;
                  else state_ff <= S_IDLE;
               end
            end
            S_IDLE: if (start) begin
               op_ff <= req_operation; first_ff <= req_first_node;
               last_ff <= req_last_node; amp_ff <= req_amplitude;
               shape_ff <= req_shape;
               val_out_ff <= '0; peak_ff <= 1'b0;
               node_ff <= '0;
               case (req_operation)
                  ppm_pkg::OP_CLEAR: begin
                     state_ff <= S_CLEAR; idx_ff <= 10'd1; status_ff <= ppm_pkg::ST_DONE;
                  end
                  ppm_pkg::OP_ADD: begin
                     state_ff <= S_CHECK; idx_ff <= '0; status_ff <= ppm_pkg::ST_DONE;
                  end
                  ppm_pkg::OP_READ: begin
                     idx_ff <= req_first_node;
                     if (11'(req_first_node) >= n_use) begin
                        status_ff <= ppm_pkg::ST_RANGE; state_ff <= S_RESP;
                     end else begin
                        status_ff <= ppm_pkg::ST_DONE; state_ff <= S_RA;
                     end
                  end
                  default: begin
                     state_ff <= S_RESP; idx_ff <= '0; status_ff <= ppm_pkg::ST_DONE;
                  end
               endcase
            end
            S_CHECK: begin
               mid_ff <= 10'((11'(first_ff) + 11'(last_ff)) >> 1);
               if (first_ff >= last_ff || 11'(last_ff) > n_last) begin
                  status_ff <= ppm_pkg::ST_RANGE; state_ff <= S_RESP;
               end else if (ppm_pkg::mag(amp_ff) < {1'b0, thr_ff}) begin
                  status_ff <= ppm_pkg::ST_SMALL; state_ff <= S_RESP;
               end else if (shape_ff == ppm_pkg::SHAPE_NONE) state_ff <= S_RESP;
               else begin node_ff <= first_ff; state_ff <= S_SETUP; end
            end
            S_SETUP: begin
               if (shape_ff == ppm_pkg::SHAPE_SINE) begin
                  fall_ff <= 1'b0;
                  den_ff <= 10'(last_ff - first_ff);
                  rem_ff <= 27'(10'(node_ff - first_ff));
               end else if (node_ff < mid_ff) begin
                  fall_ff <= 1'b0;
                  den_ff <= 10'(mid_ff - first_ff);
                  rem_ff <= 27'(10'(node_ff - first_ff));
               end else begin
                  fall_ff <= 1'b1;
                  den_ff <= 10'(last_ff - mid_ff);
                  rem_ff <= 27'(10'(node_ff - mid_ff));
               end
               quo_ff <= '0; dstep_ff <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // Restoring division; the numerator's 16 zero bits shift in below.
               if (dstep_ff == 5'd0) begin
                  if (den_ff == 10'd0) begin
                     t_ff <= 17'h10000; state_ff <= S_T;
                  end else begin
                     // Remainder starts as k; first step checks k >= d (quotient bit 16).
                     if (rem_ff >= 27'(den_ff)) begin
                        rem_ff <= 27'(rem_ff - 27'(den_ff)); quo_ff <= 17'd1;
                     end else quo_ff <= 17'd0;
                     dstep_ff <= 5'd1;
                  end
               end else if (dstep_ff == 5'd17) begin
                  t_ff <= quo_ff; state_ff <= S_T;
               end else begin
                  if (trial >= 27'(den_ff)) begin
                     rem_ff <= 27'(trial - 27'(den_ff)); quo_ff <= {quo_ff[15:0], 1'b1};
                  end else begin
                     rem_ff <= trial; quo_ff <= {quo_ff[15:0], 1'b0};
                  end
                  dstep_ff <= 5'(dstep_ff + 5'd1);
               end
            end
            S_T: begin
               if (shape_ff == ppm_pkg::SHAPE_TRI) begin
                  w_ff <= fall_ff ? 17'(17'h10000 - t_ff) : t_ff; state_ff <= S_SCALE;
               end else if (shape_ff == ppm_pkg::SHAPE_BEZ) state_ff <= S_SM1;
               else state_ff <= S_SIN1;
            end
            S_SM1: begin u_ff <= u_in >> 16; state_ff <= S_SM2; end
            S_SM2: begin
               prod_ff <= 64'(u_ff) * 64'(19'(19'h30000 - 19'({t_ff, 1'b0})));
               state_ff <= S_SM3;
            end
            S_SM3: begin
               if (((prod_ff + 64'd32768) >> 16) > 64'h10000) w_ff <= fall_ff ? '0 : 17'h10000;
               else w_ff <= fall_ff ? 17'(17'h10000 - 17'((prod_ff + 64'd32768) >> 16))
                                    : 17'((prod_ff + 64'd32768) >> 16);
               state_ff <= S_SCALE;
            end
            S_SIN1: begin
               prod_ff <= 64'(sdiff) * 64'(p32[15:0]);
               state_ff <= S_SIN2;
            end
            S_SIN2: begin
               if (t_ff[16] && t_ff[15:0] != 16'd0) w_ff <= '0;
               else if (t_ff[16]) w_ff <= '0;
               else if (sb >= sa) w_ff <= 17'(sa + 17'(prod_ff >> 16));
               else w_ff <= 17'(sa - 17'(prod_ff >> 16));
               state_ff <= S_SCALE;
            end
            S_SCALE: begin
               prod_ff <= 64'(ppm_pkg::mag(amp_ff)) * 64'(w_ff);
               state_ff <= S_RD;
            end
            S_RD: begin
               newv_ff <= amp_ff[31] ? 32'(-32'((prod_ff + 64'd32768) >> 16))
                                     : 32'((prod_ff + 64'd32768) >> 16);
               state_ff <= S_MERGE;
            end
            S_MERGE: state_ff <= S_NEXT;
            S_NEXT: begin
               if (node_ff == last_ff) state_ff <= S_RESP;
               else begin node_ff <= 10'(node_ff + 10'd1); state_ff <= S_SETUP; end
            end
            S_RA: state_ff <= S_RB;
            S_RB: begin m0_ff <= mrd_ff; state_ff <= S_RC; end
            S_RC: begin m1_ff <= mrd_ff; state_ff <= S_RD2; end
            S_RD2: begin
               val_out_ff <= m0_ff;
               if (first_ff == 10'd0 || 11'(first_ff) == n_last)
                  peak_ff <= ppm_pkg::mag(m0_ff) > ppm_pkg::mag(m1_ff);
               else
                  peak_ff <= ppm_pkg::mag(m0_ff) > ppm_pkg::mag(m1_ff) &&
                             ppm_pkg::mag(m0_ff) > ppm_pkg::mag(mrd_ff);
               state_ff <= S_RESP;
            end
            S_RESP: begin
               idx_ff <= (op_ff == ppm_pkg::OP_READ) ? idx_ff : '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

>>> rtl/ppm_checker.sv
`timescale 1ns / 1ps
module ppm_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic       rsp_is_peak,
   input logic       csr_valid,
   input logic       csr_ready
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted word did not raise busy");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response longer than one cycle");
   a_peak_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ppm_pkg::ST_DONE) |-> !rsp_is_peak)
      else $error("peak on reject");
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !busy) else $error("csr ready while busy");
endmodule

bind pulse_profile_peak_merge_top ppm_checker u_ppm_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_is_peak(rsp_is_peak),
   .csr_valid(csr_valid), .csr_ready(csr_ready)
);
